>>> sv/pfsa_pkg.sv
// Package of the per-flow sequence allocator: table size, opcodes, the stored
// entry layout and the sequencer states. Depends on nothing.
package pfsa_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        OP_ALLOCATE       = 2'd0,
        OP_FORGET_SESSION = 2'd1,
        OP_FORGET_STREAM  = 2'd2,
        OP_CLEAR_TABLE    = 2'd3
    } t_opcode;

    typedef struct packed {
        logic [15:0] stream;
        logic [15:0] session;
        logic [31:0] ssrc;
        logic [15:0] next_seq;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

>>> sv/per_flow_sequence_allocator.sv
// Top level of the per-flow sequence allocator: scan sequencer, valid bits and count.
// Depends on pfsa_pkg and pfsa_ram.
//
// A command beat is taken when start is high and busy is low. Allocate looks up
// the key (stream, session, SSRC) in a table of ENTRIES entries held in one RAM;
// forget session and forget stream erase matching entries; clear empties the table.
// Exactly one result beat follows each command, shown for one cycle with o_done.
// The receiver cannot stall; results must be taken when o_done is high.
// A clear, an incomplete allocate key or a zero forget handle shows its
// result in the cycle after the accepting edge. Other commands scan the RAM, one
// entry per cycle, through a registered RAM read, then pass a done state that
// writes back an allocate's entry and registers the result; an allocate that hits
// an entry ends its scan there. A new command may be given in the cycle the
// result is shown.
// After reset every valid bit and the entry count are cleared at once; RAM
// contents of an entry that is not valid are never used, so no clearing pass.
module per_flow_sequence_allocator
    import pfsa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_stream_handle,
    input  logic [15:0] i_session_handle,
    input  logic [31:0] i_flow_ssrc,
    input  logic [15:0] i_seed_sequence,
    output logic        o_done,
    output logic [15:0] o_sequence_out,
    output logic        o_passed_through,
    output logic        o_table_full,
    output logic [6:0]  o_entry_count
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    t_state             r_state, n_state;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_issuing, n_issuing;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]   r_cmp_idx, n_cmp_idx;
    logic               r_free_found, n_free_found;
    logic [IDX_W-1:0]   r_free_idx, n_free_idx;
    logic               r_hit, n_hit;
    logic [IDX_W-1:0]   r_hit_idx, n_hit_idx;
    logic [15:0]        r_hit_seq, n_hit_seq;
    t_opcode            r_op, n_op;
    logic [15:0]        r_stream, n_stream;
    logic [15:0]        r_session, n_session;
    logic [31:0]        r_ssrc, n_ssrc;
    logic [15:0]        r_seed, n_seed;
    logic               r_done, n_done;
    logic [15:0]        r_seq_out, n_seq_out;
    logic               r_pass, n_pass;
    logic               r_full, n_full;
    logic [CNT_W-1:0]   r_cnt_out, n_cnt_out;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_entry           ram_wdata;
    t_entry           ram_rdata;
    logic             entry_live;

    pfsa_ram #(
        .WIDTH($bits(t_entry)),
        .DEPTH(ENTRIES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_idx),
        .o_rdata(ram_rdata)
    );

    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_sequence_out   = r_seq_out;
    assign o_passed_through = r_pass;
    assign o_table_full     = r_full;
    assign o_entry_count    = 7'(r_cnt_out);
    assign entry_live       = r_valid[r_cmp_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_count   <= '0;
            r_issuing <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_count   <= n_count;
            r_issuing <= n_issuing;
            r_cmp_vld <= n_cmp_vld;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_cmp_idx    <= n_cmp_idx;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_hit        <= n_hit;
        r_hit_idx    <= n_hit_idx;
        r_hit_seq    <= n_hit_seq;
        r_op         <= n_op;
        r_stream     <= n_stream;
        r_session    <= n_session;
        r_ssrc       <= n_ssrc;
        r_seed       <= n_seed;
        r_seq_out    <= n_seq_out;
        r_pass       <= n_pass;
        r_full       <= n_full;
        r_cnt_out    <= n_cnt_out;
    end

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_count      = r_count;
        n_issuing    = r_issuing;
        n_idx        = r_idx;
        n_cmp_vld    = 1'b0;
        n_cmp_idx    = r_cmp_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_hit_seq    = r_hit_seq;
        n_op         = r_op;
        n_stream     = r_stream;
        n_session    = r_session;
        n_ssrc       = r_ssrc;
        n_seed       = r_seed;
        n_done       = 1'b0;
        n_seq_out    = r_seq_out;
        n_pass       = r_pass;
        n_full       = r_full;
        n_cnt_out    = r_cnt_out;
        ram_we       = 1'b0;
        ram_waddr    = r_hit_idx;
        ram_wdata    = '{stream: r_stream, session: r_session, ssrc: r_ssrc,
                         next_seq: r_hit_seq + 16'd1};

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op         = t_opcode'(i_opcode);
                    n_stream     = i_stream_handle;
                    n_session    = i_session_handle;
                    n_ssrc       = i_flow_ssrc;
                    n_seed       = i_seed_sequence;
                    n_idx        = '0;
                    n_free_found = 1'b0;
                    n_hit        = 1'b0;
                    n_seq_out    = 16'd0;
                    n_pass       = 1'b0;
                    n_full       = 1'b0;
                    n_cnt_out    = r_count;
                    case (t_opcode'(i_opcode))
                        OP_ALLOCATE: begin
                            if (i_stream_handle == 16'd0 || i_session_handle == 16'd0 ||
                                i_flow_ssrc == 32'd0) begin
                                n_done    = 1'b1;
                                n_seq_out = i_seed_sequence;
                                n_pass    = 1'b1;
                            end else begin
                                n_issuing = 1'b1;
                                n_state   = S_SCAN;
                            end
                        end
                        OP_FORGET_SESSION: begin
                            if (i_session_handle == 16'd0) begin
                                n_done = 1'b1;
                            end else begin
                                n_issuing = 1'b1;
                                n_state   = S_SCAN;
                            end
                        end
                        OP_FORGET_STREAM: begin
                            if (i_stream_handle == 16'd0) begin
                                n_done = 1'b1;
                            end else begin
                                n_issuing = 1'b1;
                                n_state   = S_SCAN;
                            end
                        end
                        default: begin
                            n_valid   = '0;
                            n_count   = '0;
                            n_cnt_out = '0;
                            n_done    = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_issuing) begin
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_idx;
                    if (r_idx == LAST_IDX) begin
                        n_issuing = 1'b0;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
                if (r_cmp_vld) begin
                    case (r_op)
                        OP_ALLOCATE: begin
                            if (entry_live && ram_rdata.stream == r_stream &&
                                ram_rdata.session == r_session && ram_rdata.ssrc == r_ssrc) begin
                                n_hit     = 1'b1;
                                n_hit_idx = r_cmp_idx;
                                n_hit_seq = ram_rdata.next_seq;
                                n_issuing = 1'b0;
                                n_cmp_vld = 1'b0;
                                n_state   = S_DONE;
                            end else begin
                                if (!entry_live && !r_free_found) begin
                                    n_free_found = 1'b1;
                                    n_free_idx   = r_cmp_idx;
                                end
                                if (r_cmp_idx == LAST_IDX) begin
                                    n_state = S_DONE;
                                end
                            end
                        end
                        OP_FORGET_SESSION, OP_FORGET_STREAM: begin
                            if (entry_live && ((r_op == OP_FORGET_SESSION) ?
                                (ram_rdata.session == r_session) :
                                (ram_rdata.stream == r_stream))) begin
                                n_valid[r_cmp_idx] = 1'b0;
                                n_count            = r_count - CNT_W'(1);
                            end
                            if (r_cmp_idx == LAST_IDX) begin
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                if (r_op == OP_ALLOCATE) begin
                    if (r_hit) begin
                        ram_we    = 1'b1;
                        n_seq_out = r_hit_seq;
                    end else if (r_free_found) begin
                        ram_we             = 1'b1;
                        ram_waddr          = r_free_idx;
                        ram_wdata.next_seq = r_seed + 16'd1;
                        n_valid[r_free_idx] = 1'b1;
                        n_count            = r_count + CNT_W'(1);
                        n_seq_out          = r_seed;
                    end else begin
                        n_full    = 1'b1;
                        n_seq_out = r_seed;
                    end
                end
                n_cnt_out = n_count;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_pass_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_passed_through && o_table_full))
        else $error("passed_through and table_full raised together");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRIES))
        else $error("entry count exceeds table size");

    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($countones(r_valid) == int'(r_count)))
        else $error("entry count disagrees with valid bits");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted command produced neither scan nor result");

    a_write_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_DONE && !r_cmp_vld))
        else $error("table write overlaps a scan read");
`endif

endmodule

>>> sv/pfsa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module pfsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
